### sv/rqf_pkg.sv
`timescale 1ns / 1ps

package rqf_pkg;

   // Longest read that is counted; later bases of an overlong read are dropped.
   localparam int MAX_READ_LEN = 4096;

   // Counter width holds MAX_READ_LEN itself.
   localparam int CNT_W  = $clog2(MAX_READ_LEN + 1);
   localparam int QUAL_W = 8;
   localparam int QSUM_W = CNT_W + QUAL_W;

   // Fixed register widths.
   localparam int CFG_LEN_W = 13;
   localparam int CFG_PCT_W = 7;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 13;

   // Width of the shared comparator, wide enough for every operand it sees.
   localparam int CMP_W = (QSUM_W > CFG_LEN_W) ? QSUM_W : CFG_LEN_W;

   localparam logic [CNT_W-1:0] READ_LEN_CAP = CNT_W'(MAX_READ_LEN);

   localparam logic [7:0] CHAR_N_UPPER = 8'h4E;
   localparam logic [7:0] CHAR_N_LOWER = 8'h6E;
   localparam logic [QUAL_W-1:0] PERCENT_SCALE = QUAL_W'(100);

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_QUALITY_THRESHOLD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN_QUALITY_MIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_MIN         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNKNOWN_BASE_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GOOD_PERCENT_MIN   = 3'd4;

   typedef enum logic [2:0] {
      REASON_KEEP     = 3'd0,
      REASON_SHORT    = 3'd1,
      REASON_MANY_N   = 3'd2,
      REASON_LOW_MEAN = 3'd3,
      REASON_LOW_GOOD = 3'd4
   } reason_type;

   typedef enum logic [2:0] {
      JS_IDLE,
      JS_LEN,
      JS_UNK,
      JS_MEAN,
      JS_PCT,
      JS_DONE
   } judge_state_type;

   typedef struct packed {
      logic [7:0]        base_char;
      logic [QUAL_W-1:0] quality;
      logic              last_base;
   } req_type;

   typedef struct packed {
      logic       keep;
      logic [2:0] reject_reason;
   } rsp_type;

   typedef struct packed {
      logic [QUAL_W-1:0]    quality_threshold;
      logic [QUAL_W-1:0]    mean_quality_min;
      logic [CFG_LEN_W-1:0] length_min;
      logic [CFG_LEN_W-1:0] unknown_base_limit;
      logic [CFG_PCT_W-1:0] good_percent_min;
   } config_type;

   typedef struct packed {
      logic [CNT_W-1:0]  base_count;
      logic [CNT_W-1:0]  good_count;
      logic [CNT_W-1:0]  unknown_count;
      logic [QSUM_W-1:0] quality_sum;
   } counts_type;

   typedef struct packed {
      logic       busy;
      logic       done;
      reason_type reason;
   } judge_status_type;

endpackage

### sv/sequencing_read_quality_filter_top.sv
`timescale 1ns / 1ps

// Read quality filter: bases of a read are taken one per cycle while req_stall is low,
// and running counts of bases, good bases, N bases and the quality sum are kept
// (saturating at MAX_READ_LEN bases). The item carrying the last base starts the
// verdict, which runs on one shared multiplier and comparator over at most four steps.
// The first failing check ends the verdict early. req_stall is high while the verdict
// runs, and it stays high while an earlier verdict still waits on rsp_stall.
// The user must write registers only while no read is in flight; the block itself
// does not enforce this.
module sequencing_read_quality_filter_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  rqf_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output rqf_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rqf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rqf_pkg::CSR_DAT_W-1:0]   csr_data
);
   import rqf_pkg::*;

   config_type       cfg_ff, cfg_in;
   counts_type       counts_ff, counts_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   judge_status_type status;

   logic req_accept;
   logic start;
   logic ack;
   logic room;
   logic is_good;
   logic is_unknown;

   assign req_stall  = status.busy;
   assign req_accept = req_valid && !req_stall;
   assign start      = req_accept && req_data.last_base;
   assign ack        = status.done && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready  = 1'b1;

   assign room       = counts_ff.base_count < READ_LEN_CAP;
   assign is_good    = req_data.quality >= cfg_ff.quality_threshold;
   assign is_unknown = (req_data.base_char == CHAR_N_UPPER)
                    || (req_data.base_char == CHAR_N_LOWER);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_QUALITY_THRESHOLD:  cfg_in.quality_threshold  = csr_data[QUAL_W-1:0];
            CSR_MEAN_QUALITY_MIN:   cfg_in.mean_quality_min   = csr_data[QUAL_W-1:0];
            CSR_LENGTH_MIN:         cfg_in.length_min         = csr_data[CFG_LEN_W-1:0];
            CSR_UNKNOWN_BASE_LIMIT: cfg_in.unknown_base_limit = csr_data[CFG_LEN_W-1:0];
            CSR_GOOD_PERCENT_MIN:   cfg_in.good_percent_min   = csr_data[CFG_PCT_W-1:0];
            default: ;
         endcase
      end
   end

   // Counts stay frozen while the judge works, and clear once its verdict is taken.
   always_comb begin
      counts_in = counts_ff;
      if (ack) begin
         counts_in = '0;
      end else if (req_accept && room) begin
         counts_in.base_count  = counts_ff.base_count + CNT_W'(1);
         counts_in.good_count  = counts_ff.good_count + CNT_W'(is_good);
         counts_in.unknown_count = counts_ff.unknown_count + CNT_W'(is_unknown);
         counts_in.quality_sum = counts_ff.quality_sum + QSUM_W'(req_data.quality);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ack) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.keep          = (status.reason == REASON_KEEP);
         rsp_data_in.reject_reason = status.reason;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quality_threshold  <= QUAL_W'(0);
         cfg_ff.mean_quality_min   <= QUAL_W'(20);
         cfg_ff.length_min         <= CFG_LEN_W'(0);
         cfg_ff.unknown_base_limit <= CFG_LEN_W'(99);
         cfg_ff.good_percent_min   <= CFG_PCT_W'(0);
         counts_ff                 <= '0;
         rsp_valid_ff              <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         counts_ff    <= counts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   rqf_judge u_judge (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .ack    (ack),
      .cfg    (cfg_ff),
      .counts (counts_ff),
      .status (status)
   );

endmodule

### sv/rqf_judge.sv
`timescale 1ns / 1ps

module rqf_judge (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      ack,
   input  rqf_pkg::config_type       cfg,
   input  rqf_pkg::counts_type       counts,
   output rqf_pkg::judge_status_type status
);
   import rqf_pkg::*;

   judge_state_type state_ff, state_in;
   reason_type      reason_ff, reason_in;
   logic [QSUM_W-1:0] prod_ff, prod_in;
   logic [QSUM_W-1:0] hold_ff, hold_in;

   logic [QUAL_W-1:0] mul_a;
   logic [CNT_W-1:0]  mul_b;
   logic [QSUM_W-1:0] mul_p;
   logic [CMP_W-1:0]  cmp_lhs;
   logic [CMP_W-1:0]  cmp_rhs;
   logic              cmp_lt;
   logic              load_prod;
   logic              load_hold;
   logic              load_reason;
   reason_type        reason_val;

   // Shared multiplier and comparator. A floor quotient is below a bound exactly
   // when the dividend is below the bound times the divisor, so no divider is needed.
   assign mul_p  = QSUM_W'(mul_a) * QSUM_W'(mul_b);
   assign cmp_lt = cmp_lhs < cmp_rhs;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         JS_IDLE: if (start) state_in = JS_LEN;
         JS_LEN:  state_in = cmp_lt ? JS_DONE : JS_UNK;
         JS_UNK:  state_in = cmp_lt ? JS_DONE : JS_MEAN;
         JS_MEAN: state_in = cmp_lt ? JS_DONE : JS_PCT;
         JS_PCT:  state_in = JS_DONE;
         JS_DONE: if (ack) state_in = JS_IDLE;
         default: state_in = JS_IDLE;
      endcase
   end

   always_comb begin
      mul_a       = '0;
      mul_b       = '0;
      cmp_lhs     = '0;
      cmp_rhs     = '0;
      load_prod   = 1'b0;
      load_hold   = 1'b0;
      load_reason = 1'b0;
      reason_val  = REASON_KEEP;
      status.busy = 1'b1;
      status.done = 1'b0;
      unique case (state_ff)
         JS_IDLE: begin
            status.busy = 1'b0;
         end
         JS_LEN: begin
            cmp_lhs     = CMP_W'(counts.base_count);
            cmp_rhs     = CMP_W'(cfg.length_min);
            load_reason = cmp_lt;
            reason_val  = REASON_SHORT;
            mul_a       = cfg.mean_quality_min;
            mul_b       = counts.base_count;
            load_prod   = 1'b1;
         end
         JS_UNK: begin
            cmp_lhs     = CMP_W'(cfg.unknown_base_limit);
            cmp_rhs     = CMP_W'(counts.unknown_count);
            load_reason = cmp_lt;
            reason_val  = REASON_MANY_N;
            mul_a       = PERCENT_SCALE;
            mul_b       = counts.good_count;
            load_hold   = 1'b1;
         end
         JS_MEAN: begin
            cmp_lhs     = CMP_W'(counts.quality_sum);
            cmp_rhs     = CMP_W'(prod_ff);
            load_reason = cmp_lt;
            reason_val  = REASON_LOW_MEAN;
            mul_a       = QUAL_W'(cfg.good_percent_min);
            mul_b       = counts.base_count;
            load_prod   = 1'b1;
         end
         JS_PCT: begin
            cmp_lhs     = CMP_W'(hold_ff);
            cmp_rhs     = CMP_W'(prod_ff);
            load_reason = 1'b1;
            reason_val  = cmp_lt ? REASON_LOW_GOOD : REASON_KEEP;
         end
         JS_DONE: begin
            status.done = 1'b1;
         end
         default: begin
            status.busy = 1'b0;
         end
      endcase
      status.reason = reason_ff;
   end

   assign prod_in   = load_prod ? mul_p : prod_ff;
   assign hold_in   = load_hold ? mul_p : hold_ff;
   assign reason_in = load_reason ? reason_val : reason_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= JS_IDLE;
         reason_ff <= REASON_KEEP;
      end else begin
         state_ff  <= state_in;
         reason_ff <= reason_in;
      end
      prod_ff <= prod_in;
      hold_ff <= hold_in;
   end

`ifndef ASSERT_OFF
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == JS_IDLE)
      else $error("verdict started while the previous one is still in progress");

   a_ack_done: assert property (@(posedge clock) disable iff (reset)
      ack |-> status.done)
      else $error("verdict taken before it was ready");

   a_ack_frees: assert property (@(posedge clock) disable iff (reset)
      ack |=> !status.busy)
      else $error("judge still busy after its verdict was taken");

   a_short_ok: assert property (@(posedge clock) disable iff (reset)
      status.done && status.reason == REASON_SHORT
      |-> CMP_W'(counts.base_count) < CMP_W'(cfg.length_min))
      else $error("short verdict on a read that is long enough");

   a_many_n_ok: assert property (@(posedge clock) disable iff (reset)
      status.done && status.reason == REASON_MANY_N
      |-> CMP_W'(counts.unknown_count) > CMP_W'(cfg.unknown_base_limit))
      else $error("unknown base verdict within the limit");
`endif

endmodule

### tb/read_verdict_checker.sv
`timescale 1ns / 1ps

module read_verdict_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  rqf_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  rqf_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [rqf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rqf_pkg::CSR_DAT_W-1:0] csr_data,
   output int                            failure_count,
   output int                            verdicts_pending
);
   import rqf_pkg::*;

   logic [QUAL_W-1:0]    threshold_cfg;
   logic [QUAL_W-1:0]    mean_min_cfg;
   logic [CFG_LEN_W-1:0] length_min_cfg;
   logic [CFG_LEN_W-1:0] unknown_limit_cfg;
   logic [CFG_PCT_W-1:0] percent_min_cfg;

   int base_total;
   int good_total;
   int quality_total;
   int unknown_total;

   rsp_type expected_verdicts[$];

   // The first failing check decides the reason, in the order the checks are listed.
   function automatic reason_type read_verdict();
      int len;
      len = (base_total == 0) ? 1 : base_total;
      if (len < int'(length_min_cfg))
         return REASON_SHORT;
      if (unknown_total > int'(unknown_limit_cfg))
         return REASON_MANY_N;
      if (quality_total / len < int'(mean_min_cfg))
         return REASON_LOW_MEAN;
      if ((good_total * int'(PERCENT_SCALE)) / len < int'(percent_min_cfg))
         return REASON_LOW_GOOD;
      return REASON_KEEP;
   endfunction

   always @(posedge clock) begin
      reason_type verdict;
      rsp_type    want;
      if (reset) begin
         threshold_cfg     = '0;
         mean_min_cfg      = QUAL_W'(20);
         length_min_cfg    = '0;
         unknown_limit_cfg = CFG_LEN_W'(99);
         percent_min_cfg   = '0;
         base_total        = 0;
         good_total        = 0;
         quality_total     = 0;
         unknown_total     = 0;
         failure_count     = 0;
         expected_verdicts.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_QUALITY_THRESHOLD:  threshold_cfg     = csr_data[QUAL_W-1:0];
               CSR_MEAN_QUALITY_MIN:   mean_min_cfg      = csr_data[QUAL_W-1:0];
               CSR_LENGTH_MIN:         length_min_cfg    = csr_data[CFG_LEN_W-1:0];
               CSR_UNKNOWN_BASE_LIMIT: unknown_limit_cfg = csr_data[CFG_LEN_W-1:0];
               CSR_GOOD_PERCENT_MIN:   percent_min_cfg   = csr_data[CFG_PCT_W-1:0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            // Bases beyond the length cap are dropped from every count.
            if (base_total < MAX_READ_LEN) begin
               base_total++;
               if (req_data.quality >= threshold_cfg)
                  good_total++;
               quality_total += int'(req_data.quality);
               if (req_data.base_char == CHAR_N_UPPER || req_data.base_char == CHAR_N_LOWER)
                  unknown_total++;
            end
            if (req_data.last_base) begin
               verdict = read_verdict();
               expected_verdicts.push_back('{keep: (verdict == REASON_KEEP),
                                             reject_reason: verdict});
               base_total    = 0;
               good_total    = 0;
               quality_total = 0;
               unknown_total = 0;
            end
         end

         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               $error("Result item with no verdict outstanding: keep %0d, reject_reason %0d",
                      rsp_data.keep, rsp_data.reject_reason);
               failure_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_data.keep !== want.keep) begin
                  $error("keep: expected %0d, actual %0d", want.keep, rsp_data.keep);
                  failure_count++;
               end
               if (rsp_data.reject_reason !== want.reject_reason) begin
                  $error("reject_reason: expected %0d, actual %0d",
                         want.reject_reason, rsp_data.reject_reason);
                  failure_count++;
               end
            end
         end
      end
      verdicts_pending = expected_verdicts.size();
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import rqf_pkg::*;

   localparam int IDLE_MAX      = 17;
   localparam int STALL_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_BASES  = 1800;
   localparam int SETTLE_CYCLES = 10;
   localparam int DRAIN_CYCLES  = 20;
   localparam int PRESSURE_PHASE = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = CSR_GOOD_PERCENT_MIN + 3'd1;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b1;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   int    failure_count;
   int    verdicts_pending;
   int    idle_cycles = 0;
   bit    sender_gaps = 1'b1;
   bit    receiver_gaps = 1'b1;
   bit    hold_output = 1'b0;
   string base_letters = "ACGTacgt";

   sequencing_read_quality_filter_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   read_verdict_checker verdict_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .failure_count    (failure_count),
      .verdicts_pending (verdicts_pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // The receiver normally stalls for a random count before each item; on request it
   // holds off for a long stretch so that verdicts back up into the input.
   initial begin : receiver
      int gap;
      forever begin
         if (hold_output) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_output = 1'b0;
         end else begin
            gap = receiver_gaps ? $urandom_range(0, IDLE_MAX) : 0;
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            do @(posedge clock); while (!rsp_valid && !hold_output);
         end
      end
   end

   task automatic send_base(input logic [7:0] ch, input logic [7:0] q, input logic last);
      int gap;
      gap = sender_gaps ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{base_char: ch, quality: q, last_base: last};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_read(input int len, input int n_weight);
      int q_lo;
      int q_hi;
      int r;
      logic [7:0] ch;
      q_lo = $urandom_range(0, 255);
      q_hi = $urandom_range(q_lo, 255);
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 99);
         if (r < n_weight)
            ch = r[0] ? CHAR_N_UPPER : CHAR_N_LOWER;
         else if (r < 96)
            ch = base_letters[$urandom_range(0, 7)];
         else
            ch = 8'($urandom_range(0, 255));
         send_base(ch, 8'($urandom_range(q_lo, q_hi)), i == len - 1);
      end
   endtask

   // The caller lowers csr_valid once the whole group of writes is through.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] reg_index, input int value);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data  <= CSR_DAT_W'(value);
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_config(input int threshold, input int mean_min, input int length_min,
                               input int unknown_limit, input int percent_min);
      write_reg(CSR_QUALITY_THRESHOLD, threshold);
      write_reg(CSR_MEAN_QUALITY_MIN, mean_min);
      write_reg(CSR_LENGTH_MIN, length_min);
      write_reg(CSR_UNKNOWN_BASE_LIMIT, unknown_limit);
      write_reg(CSR_GOOD_PERCENT_MIN, percent_min);
      if ($urandom_range(0, 2) == 0)
         write_reg(CSR_FIRST_UNUSED + CSR_IDX_W'($urandom_range(0, 2)),
                   $urandom_range(0, 8191));
      csr_valid <= 1'b0;
   endtask

   // Mostly a typical value; now and then an extreme or a full-width word that the
   // block has to cut down to the register's width.
   function automatic int pick_setting(input int typical_hi, input int top);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 0;
      if (r == 1)
         return top;
      if (r == 2)
         return $urandom_range(0, 8191);
      return $urandom_range(0, typical_hi);
   endfunction

   task automatic end_phase();
      req_valid <= 1'b0;
      do @(negedge clock); while (verdicts_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int random_bases;
      int phase;
      int reads;
      int len;
      random_bases = 0;
      phase = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // A read judged against the settings left by reset.
      send_base("A", 8'd30, 1'b0);
      send_base("C", 8'd10, 1'b1);
      end_phase();

      // One read per reason, an exactly-met percentage and the byte extremes.
      write_config(30, 25, 3, 1, 50);
      send_base("G", 8'd40, 1'b1);
      send_base(CHAR_N_UPPER, 8'd40, 1'b0);
      send_base(CHAR_N_LOWER, 8'd40, 1'b0);
      send_base("A", 8'd40, 1'b1);
      send_base("A", 8'd0, 1'b0);
      send_base("C", 8'd0, 1'b0);
      send_base("T", 8'd0, 1'b1);
      send_base("A", 8'd255, 1'b0);
      send_base("C", 8'd10, 1'b0);
      send_base("G", 8'd10, 1'b0);
      send_base("T", 8'd10, 1'b1);
      send_base(8'h00, 8'd255, 1'b0);
      send_base(8'hFF, 8'd255, 1'b0);
      send_base(CHAR_N_UPPER, 8'd30, 1'b1);
      send_base("A", 8'd30, 1'b0);
      send_base("C", 8'd30, 1'b0);
      send_base("G", 8'd29, 1'b0);
      send_base("T", 8'd29, 1'b1);
      end_phase();

      // Full-width words: the percentage register ends up above one hundred.
      write_config(8191, 16'h1F00, 0, 0, 8191);
      send_base("A", 8'd255, 1'b1);
      end_phase();

      while (random_bases < RANDOM_BASES) begin
         phase++;
         write_config(pick_setting(255, 255), pick_setting(200, 255),
                      pick_setting(20, MAX_READ_LEN), pick_setting(6, MAX_READ_LEN),
                      pick_setting(100, 127));
         sender_gaps   = ($urandom_range(0, 3) != 0);
         receiver_gaps = ($urandom_range(0, 3) != 0);
         if (phase == PRESSURE_PHASE) begin
            hold_output = 1'b1;
            sender_gaps = 1'b0;
            reads = 40;
         end else begin
            reads = $urandom_range(2, 12);
         end
         repeat (reads) begin
            if (phase == PRESSURE_PHASE)
               len = $urandom_range(1, 3);
            else if ($urandom_range(0, 9) == 0)
               len = $urandom_range(25, 300);
            else
               len = $urandom_range(1, 24);
            send_read(len, $urandom_range(0, 30));
            random_bases += len;
         end
         end_phase();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failure_count == 0 && verdicts_pending == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

### filelist.f
sv/rqf_pkg.sv
sv/rqf_judge.sv
sv/sequencing_read_quality_filter_top.sv
tb/read_verdict_checker.sv
tb/tb_top.sv
